// ----- design/text_console_writer_with_scroll_defines.svh -----
// Assertion macros used by the console checker file
`ifndef TEXT_CONSOLE_WRITER_WITH_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_WITH_SCROLL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tcws_pkg.sv -----
// Shared types and constants of the text console writer
package tcws_pkg;

  // Payload field widths
  localparam int unsigned IdxW  = 11;
  localparam int unsigned ByteW = 8;

  // Blank cell: space, white on black
  localparam logic [ByteW-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ByteW-1:0] BLANK_ATTR   = 8'h0F;
  localparam logic [ByteW-1:0] NEWLINE_CODE = 8'h0A;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Input item
  typedef struct packed {
    logic [1:0]       cmd;
    logic [ByteW-1:0] char_code;
    logic [ByteW-1:0] attr;
    logic [IdxW-1:0]  cell_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [IdxW-1:0]  cursor_pos;
    logic [ByteW-1:0] cell_char;
    logic [ByteW-1:0] cell_attr;
    logic             scrolled;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_PUT,
    DP_READ,
    DP_COPY,
    DP_DRAIN,
    DP_BLANK,
    DP_CLEAR,
    DP_RESULT
  } dp_op_e;

  // Controller to datapath
  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] item_cmd;   // command of the held item
    logic       wrap;       // put or newline would run past the last cell
    logic       copy_end;   // sweep is at the last cell to move up
    logic       sweep_end;  // sweep is at the last cell of the store
    logic       out_free;   // result register can take a result this cycle
  } dp_status_t;

endpackage

// ----- design/tcws_ctrl.sv -----
// Sequencer of the text console writer: picks one datapath operation per cycle
module tcws_ctrl
  import tcws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status_i.item_cmd)
          CMD_PUT:   state_d = ST_PUT;
          CMD_CLEAR: state_d = ST_CLEAR;
          CMD_READ:  state_d = ST_READ;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_PUT: begin
        state_d = status_i.wrap ? ST_COPY : ST_DONE;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_COPY: begin
        if (status_i.copy_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (status_i.sweep_end) state_d = ST_DONE;
      end
      ST_CLEAR: begin
        if (status_i.sweep_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op   = DP_IDLE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT:     cmd_o.op = DP_CLEAR;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_DISPATCH: cmd_o.op = DP_IDLE;
      ST_PUT:      cmd_o.op = DP_PUT;
      ST_READ:     cmd_o.op = DP_READ;
      ST_COPY:     cmd_o.op = DP_COPY;
      ST_DRAIN:    cmd_o.op = DP_DRAIN;
      ST_BLANK:    cmd_o.op = DP_BLANK;
      ST_CLEAR:    cmd_o.op = DP_CLEAR;
      ST_DONE: begin
        if (status_i.out_free) cmd_o.op = DP_RESULT;
      end
      default:     cmd_o.op = DP_IDLE;
    endcase
  end

endmodule

// ----- design/tcws_datapath.sv -----
// Datapath of the text console writer: cell store, cursor, sweep counter, result register
module tcws_datapath
  import tcws_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  localparam int unsigned CELLS      = COLUMNS * ROWS;
  localparam int unsigned COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW         = $clog2(CELLS);
  localparam int unsigned CW         = $clog2(COLUMNS);
  localparam int unsigned RW         = $clog2(ROWS);
  localparam int unsigned DW         = 2 * ByteW;

  // Cell store: char byte above color byte, no reset (swept after reset)
  logic [DW-1:0] mem [CELLS];

  in_item_t      item_q;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] sweep_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic [DW-1:0] rd_data_q;
  logic          read_ok_q;
  logic          scrolled_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic          is_newline, col_last, row_last, row_adv, wrap, read_in_range;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [DW-1:0] wd;

  // Cursor position decode
  assign is_newline    = (item_q.char_code == NEWLINE_CODE);
  assign col_last      = (col_q == CW'(COLUMNS - 1));
  assign row_last      = (row_q == RW'(ROWS - 1));
  assign row_adv       = is_newline || col_last;
  assign wrap          = row_adv && row_last;
  assign read_in_range = (32'(item_q.cell_index) < 32'(CELLS));

  // Status to the controller
  assign status_o.item_cmd  = item_q.cmd;
  assign status_o.wrap      = wrap;
  assign status_o.copy_end  = (sweep_q == AW'(COPY_CELLS - 1));
  assign status_o.sweep_end = (sweep_q == AW'(CELLS - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Store port selection
  always_comb begin
    we = 1'b0;
    wa = cursor_q;
    wd = {item_q.char_code, item_q.attr};
    re = 1'b0;
    ra = sweep_q + AW'(COLUMNS);
    case (cmd_i.op)
      DP_PUT: begin
        we = !is_newline;
      end
      DP_COPY: begin
        // read one row ahead, write the cell read last cycle
        re = 1'b1;
        we = pend_q;
        wa = pend_addr_q;
        wd = rd_data_q;
      end
      DP_DRAIN: begin
        we = pend_q;
        wa = pend_addr_q;
        wd = rd_data_q;
      end
      DP_CLEAR, DP_BLANK: begin
        we = 1'b1;
        wa = sweep_q;
        wd = {BLANK_CHAR, BLANK_ATTR};
      end
      DP_READ: begin
        re = 1'b1;
        ra = AW'(item_q.cell_index);
      end
      default: ;
    endcase
  end

  // Cell store ports
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_data_q <= mem[ra];
  end

  // Cursor update
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    row_d    = row_q;
    case (cmd_i.op)
      DP_PUT: begin
        if (wrap) begin
          cursor_d = AW'(COPY_CELLS);
          col_d    = '0;
          row_d    = RW'(ROWS - 1);
        end else if (is_newline) begin
          cursor_d = cursor_q - AW'(col_q) + AW'(COLUMNS);
          col_d    = '0;
          row_d    = row_q + 1'b1;
        end else if (col_last) begin
          cursor_d = cursor_q + 1'b1;
          col_d    = '0;
          row_d    = row_q + 1'b1;
        end else begin
          cursor_d = cursor_q + 1'b1;
          col_d    = col_q + 1'b1;
        end
      end
      DP_CLEAR: begin
        cursor_d = '0;
        col_d    = '0;
        row_d    = '0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
      row_q    <= row_d;
      case (cmd_i.op)
        DP_LOAD: begin
          sweep_q <= '0;
          pend_q  <= 1'b0;
        end
        DP_COPY: begin
          sweep_q <= sweep_q + 1'b1;
          pend_q  <= 1'b1;
        end
        DP_DRAIN: pend_q <= 1'b0;
        DP_CLEAR, DP_BLANK: sweep_q <= sweep_q + 1'b1;
        default: ;
      endcase
      // result register valid
      if (cmd_i.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        item_q     <= in_data_i;
        read_ok_q  <= 1'b0;
        scrolled_q <= 1'b0;
      end
      DP_PUT:  scrolled_q <= wrap;
      DP_READ: read_ok_q  <= read_in_range;
      DP_COPY: pend_addr_q <= sweep_q;
      DP_RESULT: begin
        out_q.cursor_pos <= IdxW'(cursor_q);
        out_q.cell_char  <= read_ok_q ? rd_data_q[DW-1:ByteW] : '0;
        out_q.cell_attr  <= read_ok_q ? rd_data_q[ByteW-1:0] : '0;
        out_q.scrolled   <= scrolled_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/text_console_writer_with_scroll.sv -----
// Top level of the text console writer with one-row scroll
//
// Text console over a COLUMNS x ROWS cell store (char byte, color byte)
// with a cursor. One result per command. Each command is loaded, decoded
// and carried out, and its result is written to the output register; the
// next command is taken once the result sits in the output register, even
// if it has not been transferred yet. A put or newline that runs past the
// last cell scrolls: the rows are moved up one row and the bottom row is
// then blanked. A clear blanks the whole store. After reset the store is
// blanked by a pass during which in_stall_o stays high. The cell store has
// a single write port, which moves or blanks one cell per cycle.
module text_console_writer_with_scroll
  import tcws_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer
  tcws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .in_stall_o (in_stall_o)
  );

  // Store, cursor and result register
  tcws_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/tcws_checker.sv -----
// Port-level checks of the text console writer, bound to the top level
`include "text_console_writer_with_scroll_defines.svh"

module tcws_checker
  import tcws_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  localparam int unsigned CELLS     = COLUMNS * ROWS;
  localparam int unsigned LAST_ROW  = (ROWS - 1) * COLUMNS;
  localparam int unsigned IDX_LIMIT = 1 << IdxW;

  // A held result stays offered
  `TCWS_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i, "result dropped while stalled")

  // One command at a time: a transfer closes the input for the next cycle
  `TCWS_ASSERT_NXT(a_one_item, in_valid_i && !in_stall_i, in_stall_i, "input open right after a transfer")

  // Cursor never leaves the store
  `TCWS_ASSERT_IMP(a_cursor_range, out_valid_i, (32'(out_data_i.cursor_pos) < 32'(CELLS)) || (CELLS > IDX_LIMIT), "cursor out of range")

  // A scroll leaves the cursor at the start of the bottom row
  `TCWS_ASSERT_IMP(a_scroll_cursor, out_valid_i && out_data_i.scrolled, out_data_i.cursor_pos == IdxW'(LAST_ROW), "scroll cursor wrong")

  // Only reads return cell data, and reads never scroll
  `TCWS_ASSERT_IMP(a_scroll_no_cell, out_valid_i && out_data_i.scrolled, (out_data_i.cell_char == '0) && (out_data_i.cell_attr == '0), "scroll carries cell data")

endmodule

bind text_console_writer_with_scroll tcws_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
